/* rtl/parallel_byte_fifo_audio_sampler_top_assert.svh */
// Assertion macros shared by the sampler RTL.
`ifndef PARALLEL_BYTE_FIFO_AUDIO_SAMPLER_TOP_ASSERT_SVH
`define PARALLEL_BYTE_FIFO_AUDIO_SAMPLER_TOP_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define PBFAS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define PBFAS_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/pbfas_pkg.sv */
// Types and constants shared by the sampler modules.
package pbfas_pkg;

    localparam int BYTE_W     = 8;
    localparam int SAMPLE_W   = 16;
    localparam int SLOT_OUT_W = 8;
    localparam int MAX_SHIFT  = 8;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int M_TDATA_W  = 32;

    // Item kind carried on the input tuser bit.
    typedef enum logic {
        OP_STROBE = 1'b0,
        OP_TICK   = 1'b1
    } op_t;

    // Register index taken from the APB word address.
    typedef enum logic {
        REG_VOLUME_SHIFT = 1'b0,
        REG_FULL_LEVEL   = 1'b1
    } reg_idx_t;

    // Half-done mark on the ring slot.
    typedef enum logic [1:0] {
        HALF_NONE   = 2'd0,
        HALF_FIRST  = 2'd1,
        HALF_SECOND = 2'd2
    } half_t;

    // Stage-one record handed from the pointer logic to the sample stage.
    typedef struct packed {
        logic                  is_tick;
        logic                  fetch;
        logic                  nonempty;
        logic                  full;
        logic [SLOT_OUT_W-1:0] slot;
        half_t                 half;
    } s1_t;

endpackage

/* rtl/parallel_byte_fifo_audio_sampler_top.sv */
// Path: an accepted request is registered in the stage-one register, and its result is then
// loaded into the output register, from which it leaves.
// Throughput: one request per cycle; the input stalls only while the output is held.
// The byte store is a RAM with registered read, read once per fetch tick while the FIFO holds data.
// Reset clears pointers, tick counter, full flag, held sample and the valid flags of both stages.
// The byte store has no clearing pass and is usable right after reset.
`include "parallel_byte_fifo_audio_sampler_top_assert.svh"

module parallel_byte_fifo_audio_sampler_top #(
    parameter int FIFO_DEPTH = 256,
    parameter int RING_SLOTS = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pbfas_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [pbfas_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [pbfas_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pbfas_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] data_byte
    input  logic [0:0]                        s_tuser,   // [0] opcode
    // Output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pbfas_pkg::M_TDATA_W-1:0]   m_tdata,   // [0] fifo_full, [16:1] sample,
                                                         // [24:17] slot, [26:25] half_ready
    output logic [0:0]                        m_tuser    // [0] sample_valid
);

    import pbfas_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    logic [3:0]        volume_shift;
    logic [BYTE_W-1:0] full_level;
    logic              advance;
    logic              ram_we;
    logic [PTR_W-1:0]  ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [PTR_W-1:0]  ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;
    logic              s1_valid;
    s1_t               s1;

    // Configuration registers.
    pbfas_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .volume_shift (volume_shift),
        .full_level   (full_level)
    );

    // Pointer and flag stage.
    pbfas_ctrl #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .RING_SLOTS (RING_SLOTS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser[0]),
        .full_level (full_level),
        .advance    (advance),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .s1_valid   (s1_valid),
        .s1         (s1)
    );

    // Byte store.
    pbfas_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FIFO_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sample and output stage.
    pbfas_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .s1_valid     (s1_valid),
        .s1           (s1),
        .rd_data      (ram_rdata),
        .volume_shift (volume_shift),
        .advance      (advance),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser[0])
    );

    // The input only stalls when a result is held at the output.
    `PBFAS_ASSERT(a_stall_cause, !s_tready |-> (m_tvalid && !m_tready), "input stalled without output backpressure")
    // A strobe result carries no sample, slot or half mark.
    `PBFAS_ASSERT(a_strobe_zero, (m_tvalid && !m_tuser[0]) |-> (m_tdata[26:1] == '0), "strobe result carries sample data")
    // The half mark never takes the unused code.
    `PBFAS_ASSERT_NEVER(a_half_code, m_tvalid && (m_tdata[26:25] == 2'b11), "invalid half_ready code")
    // Even slots never carry a half mark.
    `PBFAS_ASSERT_NEVER(a_half_even, m_tvalid && m_tuser[0] && !m_tdata[17] && (m_tdata[26:25] != 2'b00), "half mark on an even slot")

endmodule

/* rtl/pbfas_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pbfas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port; the data register holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/pbfas_cfg.sv */
// APB configuration registers: volume shift and full level.
module pbfas_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pbfas_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [pbfas_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [pbfas_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready,
    output logic [3:0]                        volume_shift,
    output logic [pbfas_pkg::BYTE_W-1:0]      full_level
);

    import pbfas_pkg::*;

    logic [3:0]        volume_shift_reg;
    logic [BYTE_W-1:0] full_level_reg;
    reg_idx_t          idx;
    logic              wr_en;

    assign idx    = reg_idx_t'(paddr[2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;

    // Register writes in the access cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_shift_reg <= 4'd4;
            full_level_reg   <= 8'd16;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_VOLUME_SHIFT: volume_shift_reg <= pwdata[3:0];
                REG_FULL_LEVEL:   full_level_reg   <= pwdata[BYTE_W-1:0];
                default:          ;
            endcase
        end
    end

    // Read-back mux.
    always_comb
    begin
        unique case (idx)
            REG_VOLUME_SHIFT: prdata = APB_DATA_W'(volume_shift_reg);
            REG_FULL_LEVEL:   prdata = APB_DATA_W'(full_level_reg);
            default:          prdata = '0;
        endcase
    end

    assign volume_shift = volume_shift_reg;
    assign full_level   = full_level_reg;

endmodule

/* rtl/pbfas_ctrl.sv */
// Input stage: FIFO pointers, full flag, tick counter and the stage-one register.
module pbfas_ctrl #(
    parameter int FIFO_DEPTH = 256,
    parameter int RING_SLOTS = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pbfas_pkg::BYTE_W-1:0]    s_tdata,
    input  logic                            s_tuser,
    input  logic [pbfas_pkg::BYTE_W-1:0]    full_level,
    input  logic                            advance,
    output logic                            ram_we,
    output logic [$clog2(FIFO_DEPTH)-1:0]   ram_waddr,
    output logic [pbfas_pkg::BYTE_W-1:0]    ram_wdata,
    output logic                            ram_re,
    output logic [$clog2(FIFO_DEPTH)-1:0]   ram_raddr,
    output logic                            s1_valid,
    output pbfas_pkg::s1_t                  s1
);

    import pbfas_pkg::*;

    localparam int PTR_W  = $clog2(FIFO_DEPTH);
    localparam int SLOT_W = $clog2(RING_SLOTS);
    localparam int CMP_W  = 10;
    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [PTR_W:0]    DEPTH_C   = (PTR_W + 1)'(FIFO_DEPTH);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_SLOTS - 1);
    localparam logic [SLOT_W-1:0] SLOT_HALF = SLOT_W'(RING_SLOTS / 2 - 1);

    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [SLOT_W-1:0] tick_reg, tick_next;
    logic              full_reg, full_next;
    logic              s1_valid_reg, s1_valid_next;
    s1_t               s1_reg, s1_next;

    logic              accept;
    logic              is_tick;
    logic [PTR_W-1:0]  wr_ptr_inc;
    logic [PTR_W-1:0]  rd_ptr_inc;
    logic [CMP_W-1:0]  cnt_now;
    logic [CMP_W-1:0]  cnt_push;
    logic [CMP_W-1:0]  cnt_pop;
    logic [CMP_W-1:0]  level;
    logic              nonempty;
    logic              fetch;

    // Occupancy between two pointers, modulo the FIFO depth.
    function automatic logic [CMP_W-1:0] fifo_cnt(input logic [PTR_W-1:0] wp,
                                                   input logic [PTR_W-1:0] rp);
        logic [PTR_W:0] diff;
        diff = {1'b0, wp} - {1'b0, rp};
        if (diff[PTR_W])
        begin
            diff = diff + DEPTH_C;
        end
        return CMP_W'(diff);
    endfunction

    assign s_tready = !s1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;
    assign is_tick  = (op_t'(s_tuser) == OP_TICK);

    // Pointer increments with wrap at the FIFO depth.
    assign wr_ptr_inc = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;

    // Occupancy now, after a push and after a pop.
    assign cnt_now  = fifo_cnt(wr_ptr_reg, rd_ptr_reg);
    assign cnt_push = fifo_cnt(wr_ptr_inc, rd_ptr_reg);
    assign nonempty = (cnt_now != '0);
    assign cnt_pop  = cnt_now - CMP_W'(nonempty);
    assign level    = CMP_W'(full_level);
    assign fetch    = tick_reg[0];

    // Next state for the pointers, flag, tick counter and stage-one record.
    always_comb
    begin
        wr_ptr_next   = wr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        tick_next     = tick_reg;
        full_next     = full_reg;
        s1_valid_next = s1_valid_reg;
        s1_next       = s1_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
            if (!is_tick)
            begin
                wr_ptr_next = wr_ptr_inc;
                if (cnt_push == level)
                begin
                    full_next = 1'b1;
                end
                s1_next.is_tick  = 1'b0;
                s1_next.fetch    = 1'b0;
                s1_next.nonempty = 1'b0;
                s1_next.full     = (cnt_push == level) ? 1'b1 : full_reg;
                s1_next.slot     = '0;
                s1_next.half     = HALF_NONE;
            end
            else
            begin
                tick_next = (tick_reg == SLOT_LAST) ? '0 : tick_reg + 1'b1;
                s1_next.full = full_reg;
                if (fetch)
                begin
                    if (nonempty)
                    begin
                        rd_ptr_next = rd_ptr_inc;
                    end
                    if (cnt_pop < level)
                    begin
                        full_next    = 1'b0;
                        s1_next.full = 1'b0;
                    end
                end
                s1_next.is_tick  = 1'b1;
                s1_next.fetch    = fetch;
                s1_next.nonempty = nonempty;
                s1_next.slot     = SLOT_OUT_W'(tick_reg);
                priority if (tick_reg == SLOT_LAST)
                begin
                    s1_next.half = HALF_SECOND;
                end
                else if (tick_reg == SLOT_HALF)
                begin
                    s1_next.half = HALF_FIRST;
                end
                else
                begin
                    s1_next.half = HALF_NONE;
                end
            end
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            tick_reg     <= '0;
            full_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            tick_reg     <= tick_next;
            full_reg     <= full_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Stage-one payload.
    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
    end

    // Byte store requests.
    assign ram_we    = accept && !is_tick;
    assign ram_waddr = wr_ptr_reg;
    assign ram_wdata = s_tdata;
    assign ram_re    = accept && is_tick && fetch && nonempty;
    assign ram_raddr = rd_ptr_reg;

    assign s1_valid = s1_valid_reg;
    assign s1       = s1_reg;

endmodule

/* rtl/pbfas_out.sv */
// Sample stage: centers and scales the fetched byte, holds the sample, drives the output register.
module pbfas_out (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s1_valid,
    input  pbfas_pkg::s1_t                    s1,
    input  logic [pbfas_pkg::BYTE_W-1:0]      rd_data,
    input  logic [3:0]                        volume_shift,
    output logic                              advance,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pbfas_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                              m_tuser
);

    import pbfas_pkg::*;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic                  m_tuser_reg, m_tuser_next;
    logic [SAMPLE_W-1:0]   held_reg, held_next;
    logic [SAMPLE_W-1:0]   scaled;
    logic [SAMPLE_W-1:0]   sample;
    logic                  take;

    // (byte - 128) as a signed 16-bit value, shifted left by at most 8.
    function automatic logic [SAMPLE_W-1:0] scale_byte(input logic [BYTE_W-1:0] b,
                                                       input logic [3:0] vs);
        logic [SAMPLE_W-1:0] centered;
        logic [3:0]          sh;
        centered = SAMPLE_W'(signed'({~b[BYTE_W-1], b[BYTE_W-2:0]}));
        sh       = (vs > 4'(MAX_SHIFT)) ? 4'(MAX_SHIFT) : vs;
        return centered << sh;
    endfunction

    assign advance = !m_tvalid_reg || m_tready;
    assign take    = s1_valid && advance;
    assign scaled  = scale_byte(rd_data, volume_shift);

    // Sample for this item and the new held value.
    always_comb
    begin
        held_next = held_reg;
        if (s1.is_tick && s1.fetch)
        begin
            held_next = s1.nonempty ? scaled : '0;
        end
        sample = s1.is_tick ? held_next : '0;
    end

    // Output register next state.
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (take)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = M_TDATA_W'({s1.half, s1.slot, sample, s1.full});
            m_tuser_next  = s1.is_tick;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    // Control registers and held sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
            held_reg     <= '0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
            if (take)
            begin
                held_reg <= held_next;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
